// ===== rtl/rti_pkg.sv =====
package rti_pkg;

   localparam int FIELD_WIDTH      = 21;
   localparam int DIST_WIDTH       = 20;
   localparam int REG_WIDTH        = 63;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int DEF_COORD_WIDTH  = 21;
   localparam int DEF_COORD_FRAC   = 12;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_VERTEX_A     = 3'd0;
   localparam csr_index_type REG_VERTEX_B     = 3'd1;
   localparam csr_index_type REG_VERTEX_C     = 3'd2;
   localparam csr_index_type REG_PLANE_NORMAL = 3'd3;
   localparam csr_index_type REG_PLANE_OFFSET = 3'd4;
   localparam csr_index_type REG_EPSILON      = 3'd5;

   localparam logic [DIST_WIDTH-1:0] EPSILON_RESET = 20'd4;

endpackage

// ===== rtl/rti_div_stage.sv =====
module rti_div_stage #(
   parameter int CW    = 77,
   parameter int DW    = 44,
   parameter int QB    = 20,
   parameter int SHIFT = 0,
   parameter int CTXW  = 150
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic            in_valid,
   input  logic [CW-1:0]   rem_in,
   input  logic [DW-1:0]   div_in,
   input  logic [QB-1:0]   quo_in,
   input  logic [CTXW-1:0] ctx_in,
   output logic            out_valid,
   output logic [CW-1:0]   rem_out,
   output logic [DW-1:0]   div_out,
   output logic [QB-1:0]   quo_out,
   output logic [CTXW-1:0] ctx_out
);

   logic            valid_ff;
   logic [CW-1:0]   rem_ff, rem_in_sel;
   logic [DW-1:0]   div_ff;
   logic [QB-1:0]   quo_ff, quo_in_sel;
   logic [CTXW-1:0] ctx_ff;
   logic [CW-1:0]   trial;
   logic            ge;

   assign trial = CW'(div_in) << SHIFT;
   assign ge    = rem_in >= trial;

   always_comb begin
      rem_in_sel = ge ? (rem_in - trial) : rem_in;
      quo_in_sel = quo_in;
      quo_in_sel[SHIFT] = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in_sel;
         div_ff <= div_in;
         quo_ff <= quo_in_sel;
         ctx_ff <= ctx_in;
      end
   end

   assign out_valid = valid_ff;
   assign rem_out   = rem_ff;
   assign div_out   = div_ff;
   assign quo_out   = quo_ff;
   assign ctx_out   = ctx_ff;

endmodule

// ===== rtl/ray_triangle_intersect.sv =====
// An accepted request word reaches its response word through 4 setup stages, one restoring
// divider stage per distance bit (one quotient bit a stage) and 7 arithmetic stages.
// Throughput: one ray per cycle unless stalled; the divider is fully pipelined.
// Stalls hold each stage only while the stage after it is full.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module ray_triangle_intersect #(
   parameter int COORD_WIDTH = rti_pkg::DEF_COORD_WIDTH,
   parameter int COORD_FRAC  = rti_pkg::DEF_COORD_FRAC
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  rti_pkg::csr_index_type                csr_index,
   input  logic [rti_pkg::REG_WIDTH-1:0]         csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rti_pkg::FIELD_WIDTH-1:0] req_origin_x,
   input  logic signed [rti_pkg::FIELD_WIDTH-1:0] req_origin_y,
   input  logic signed [rti_pkg::FIELD_WIDTH-1:0] req_origin_z,
   input  logic signed [rti_pkg::FIELD_WIDTH-1:0] req_dir_x,
   input  logic signed [rti_pkg::FIELD_WIDTH-1:0] req_dir_y,
   input  logic signed [rti_pkg::FIELD_WIDTH-1:0] req_dir_z,
   input  logic [rti_pkg::DIST_WIDTH-1:0]        req_max_distance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [rti_pkg::DIST_WIDTH-1:0]        rsp_distance,
   output logic                                  rsp_back_face,
   output logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_hit_x,
   output logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_hit_y,
   output logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_hit_z,
   output logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_shade_nx,
   output logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_shade_ny,
   output logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_shade_nz
);

   import rti_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int F    = COORD_FRAC;
   localparam int NF   = W - 2;
   localparam int QB   = DIST_WIDTH;
   localparam int PRW  = 2 * W;
   localparam int DW   = 2 * W + 2;
   localparam int NUMW = DW + 1;
   localparam int NW   = NUMW + F;
   localparam int CW   = NW + QB;
   localparam int EW   = QB + NF;
   localparam int PCW  = DW + EW;
   localparam int DTW  = W + QB + 1;
   localparam int SW   = DTW + 1;
   localparam int QW   = W + 1;
   localparam int XW   = 2 * QW;
   localparam int CRW  = XW + 1 - F;
   localparam int MW   = W + CRW;
   localparam int SMW  = MW + 2;
   localparam int CTXW = 6 * W + QB + 4;
   localparam int CO   = 4 + QB;
   localparam int CD   = 4 + QB + 3 * W;

   localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] sat_coord(input logic signed [SW-1:0] x);
      logic signed [W-1:0] r;
      if (x > SAT_HI) begin
         r = COORD_MAX;
      end else if (x < SAT_LO) begin
         r = COORD_MIN;
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [REG_WIDTH-1:0]   va_ff, vb_ff, vc_ff, vn_ff;
   logic [FIELD_WIDTH-1:0] off_ff;
   logic [DIST_WIDTH-1:0]  eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= '0;
         vb_ff  <= '0;
         vc_ff  <= '0;
         vn_ff  <= '0;
         off_ff <= '0;
         eps_ff <= EPSILON_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_VERTEX_A:     va_ff  <= csr_wdata;
            REG_VERTEX_B:     vb_ff  <= csr_wdata;
            REG_VERTEX_C:     vc_ff  <= csr_wdata;
            REG_PLANE_NORMAL: vn_ff  <= csr_wdata;
            REG_PLANE_OFFSET: off_ff <= csr_wdata[FIELD_WIDTH-1:0];
            REG_EPSILON:      eps_ff <= csr_wdata[DIST_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic signed [W-1:0]  ca [3], cb [3], cc [3], cn [3], cn_neg [3];
   logic signed [QW-1:0] edge_v [3][3];
   logic signed [W-1:0]  vtx [3][3];
   logic signed [W-1:0]  off_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ca[i] = va_ff[i*W +: W];
         cb[i] = vb_ff[i*W +: W];
         cc[i] = vc_ff[i*W +: W];
         cn[i] = vn_ff[i*W +: W];
         cn_neg[i] = (cn[i] == COORD_MIN) ? COORD_MAX : -cn[i];
         vtx[0][i] = ca[i];
         vtx[1][i] = cb[i];
         vtx[2][i] = cc[i];
         edge_v[0][i] = QW'(cb[i]) - QW'(ca[i]);
         edge_v[1][i] = QW'(cc[i]) - QW'(cb[i]);
         edge_v[2][i] = QW'(ca[i]) - QW'(cc[i]);
      end
      off_c = off_ff[W-1:0];
   end

   // Stage ready chain, from the output back to the input.
   logic rdy_1, rdy_2, rdy_3, rdy_4, rdy_t, rdy_p, rdy_q, rdy_x, rdy_c, rdy_m, rdy_o;
   logic v1_ff, v2_ff, v3_ff, v4_ff, vt_ff, vp_ff, vq_ff, vx_ff, vc_ff2, vm_ff, vo_ff;
   logic            div_v   [QB];
   logic            div_rdy [QB];
   logic [CW-1:0]   div_rem [QB];
   logic [DW-1:0]   div_d   [QB];
   logic [QB-1:0]   div_q   [QB];
   logic [CTXW-1:0] div_ctx [QB];

   assign rdy_o = !vo_ff  || !rsp_stall;
   assign rdy_m = !vm_ff  || rdy_o;
   assign rdy_c = !vc_ff2 || rdy_m;
   assign rdy_x = !vx_ff  || rdy_c;
   assign rdy_q = !vq_ff  || rdy_x;
   assign rdy_p = !vp_ff  || rdy_q;
   assign rdy_t = !vt_ff  || rdy_p;
   assign rdy_4 = !v4_ff  || div_rdy[0];
   assign rdy_3 = !v3_ff  || rdy_4;
   assign rdy_2 = !v2_ff  || rdy_3;
   assign rdy_1 = !v1_ff  || rdy_2;
   assign req_stall = !rdy_1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         vt_ff  <= 1'b0;
         vp_ff  <= 1'b0;
         vq_ff  <= 1'b0;
         vx_ff  <= 1'b0;
         vc_ff2 <= 1'b0;
         vm_ff  <= 1'b0;
         vo_ff  <= 1'b0;
      end else begin
         if (rdy_1) v1_ff  <= req_valid;
         if (rdy_2) v2_ff  <= v1_ff;
         if (rdy_3) v3_ff  <= v2_ff;
         if (rdy_4) v4_ff  <= v3_ff;
         if (rdy_t) vt_ff  <= div_v[QB-1];
         if (rdy_p) vp_ff  <= vt_ff;
         if (rdy_q) vq_ff  <= vp_ff;
         if (rdy_x) vx_ff  <= vq_ff;
         if (rdy_c) vc_ff2 <= vx_ff;
         if (rdy_m) vm_ff  <= vc_ff2;
         if (rdy_o) vo_ff  <= vm_ff;
      end
   end

   // Stage 1: normal products with direction and origin.
   logic signed [W-1:0]   o_in [3], d_in [3];
   logic signed [W-1:0]   o1_ff [3], d1_ff [3];
   logic signed [PRW-1:0] pnd_ff [3], pno_ff [3];
   logic [QB-1:0]         tmax1_ff;

   always_comb begin
      o_in[0] = req_origin_x[W-1:0];
      o_in[1] = req_origin_y[W-1:0];
      o_in[2] = req_origin_z[W-1:0];
      d_in[0] = req_dir_x[W-1:0];
      d_in[1] = req_dir_y[W-1:0];
      d_in[2] = req_dir_z[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy_1) begin
         for (int i = 0; i < 3; i++) begin
            o1_ff[i]  <= o_in[i];
            d1_ff[i]  <= d_in[i];
            pnd_ff[i] <= PRW'(cn[i]) * PRW'(d_in[i]);
            pno_ff[i] <= PRW'(cn[i]) * PRW'(o_in[i]);
         end
         tmax1_ff <= req_max_distance;
      end
   end

   // Stage 2: dot products and plane numerator.
   logic signed [W-1:0]    o2_ff [3], d2_ff [3];
   logic [QB-1:0]          tmax2_ff;
   logic signed [DW-1:0]   nd2_ff;
   logic signed [NUMW-1:0] num2_ff;
   logic signed [DW-1:0]   no_sum;

   assign no_sum = DW'(pno_ff[0]) + DW'(pno_ff[1]) + DW'(pno_ff[2]);

   always_ff @(posedge clock) begin
      if (rdy_2) begin
         o2_ff    <= o1_ff;
         d2_ff    <= d1_ff;
         tmax2_ff <= tmax1_ff;
         nd2_ff   <= DW'(pnd_ff[0]) + DW'(pnd_ff[1]) + DW'(pnd_ff[2]);
         num2_ff  <= NUMW'($signed({off_c, {NF{1'b0}}})) - NUMW'(no_sum);
      end
   end

   // Stage 3: magnitudes and the parallel test.
   logic signed [W-1:0] o3_ff [3], d3_ff [3];
   logic [QB-1:0]       tmax3_ff;
   logic [DW-1:0]       dmag, dmag3_ff;
   logic [NUMW-1:0]     nmag;
   logic [NW-1:0]       nsh3_ff;
   logic                par_miss, par3_ff, back3_ff, qneg3_ff;

   assign dmag = nd2_ff[DW-1] ? DW'(~nd2_ff + 1'b1) : DW'(nd2_ff);
   assign nmag = num2_ff[NUMW-1] ? NUMW'(~num2_ff + 1'b1) : NUMW'(num2_ff);
   assign par_miss = (PCW'(dmag) < PCW'({eps_ff, {NF{1'b0}}})) || (dmag == '0);

   always_ff @(posedge clock) begin
      if (rdy_3) begin
         o3_ff    <= o2_ff;
         d3_ff    <= d2_ff;
         tmax3_ff <= tmax2_ff;
         dmag3_ff <= dmag;
         nsh3_ff  <= {nmag, {F{1'b0}}};
         par3_ff  <= par_miss;
         back3_ff <= nd2_ff[DW-1];
         qneg3_ff <= nd2_ff[DW-1] ^ num2_ff[NUMW-1];
      end
   end

   // Stage 4: quotient overflow check.
   logic signed [W-1:0] o4_ff [3], d4_ff [3];
   logic [QB-1:0]       tmax4_ff;
   logic [DW-1:0]       dmag4_ff;
   logic [CW-1:0]       rem4_ff;
   logic                par4_ff, back4_ff, qneg4_ff, ovf4_ff;
   logic [CTXW-1:0]     ctx4;

   always_ff @(posedge clock) begin
      if (rdy_4) begin
         o4_ff    <= o3_ff;
         d4_ff    <= d3_ff;
         tmax4_ff <= tmax3_ff;
         dmag4_ff <= dmag3_ff;
         rem4_ff  <= CW'(nsh3_ff);
         par4_ff  <= par3_ff;
         back4_ff <= back3_ff;
         qneg4_ff <= qneg3_ff;
         ovf4_ff  <= CW'(nsh3_ff) >= (CW'(dmag3_ff) << QB);
      end
   end

   always_comb begin
      ctx4 = '0;
      ctx4[0] = ovf4_ff;
      ctx4[1] = par4_ff;
      ctx4[2] = qneg4_ff;
      ctx4[3] = back4_ff;
      ctx4[4 +: QB] = tmax4_ff;
      for (int i = 0; i < 3; i++) begin
         ctx4[CO + i*W +: W] = o4_ff[i];
         ctx4[CD + i*W +: W] = d4_ff[i];
      end
   end

   // Restoring divider, one quotient bit per stage, most significant first.
   for (genvar k = 0; k < QB; k++) begin : g_div
      logic            in_v;
      logic [CW-1:0]   in_rem;
      logic [DW-1:0]   in_d;
      logic [QB-1:0]   in_q;
      logic [CTXW-1:0] in_ctx;

      if (k == 0) begin : g_first
         assign in_v   = v4_ff;
         assign in_rem = rem4_ff;
         assign in_d   = dmag4_ff;
         assign in_q   = '0;
         assign in_ctx = ctx4;
      end else begin : g_next
         assign in_v   = div_v[k-1];
         assign in_rem = div_rem[k-1];
         assign in_d   = div_d[k-1];
         assign in_q   = div_q[k-1];
         assign in_ctx = div_ctx[k-1];
      end

      if (k == QB - 1) begin : g_last_rdy
         assign div_rdy[k] = !div_v[k] || rdy_t;
      end else begin : g_mid_rdy
         assign div_rdy[k] = !div_v[k] || div_rdy[k+1];
      end

      rti_div_stage #(
         .CW    (CW),
         .DW    (DW),
         .QB    (QB),
         .SHIFT (QB - 1 - k),
         .CTXW  (CTXW)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .load      (div_rdy[k]),
         .in_valid  (in_v),
         .rem_in    (in_rem),
         .div_in    (in_d),
         .quo_in    (in_q),
         .ctx_in    (in_ctx),
         .out_valid (div_v[k]),
         .rem_out   (div_rem[k]),
         .div_out   (div_d[k]),
         .quo_out   (div_q[k]),
         .ctx_out   (div_ctx[k])
      );
   end

   // Stage T: distance range test and direction scaling.
   logic [CTXW-1:0]       ctx_t;
   logic [QB-1:0]         q_t, tmax_t;
   logic                  miss_t;
   logic signed [W-1:0]   o_t [3], d_t [3];
   logic signed [W-1:0]   ot_ff [3];
   logic signed [DTW-1:0] dtp_ff [3];
   logic [QB-1:0]         tt_ff;
   logic                  missT_ff, backT_ff;

   always_comb begin
      ctx_t  = div_ctx[QB-1];
      q_t    = div_q[QB-1];
      tmax_t = ctx_t[4 +: QB];
      for (int i = 0; i < 3; i++) begin
         o_t[i] = ctx_t[CO + i*W +: W];
         d_t[i] = ctx_t[CD + i*W +: W];
      end
      miss_t = ctx_t[0] || ctx_t[1] || (ctx_t[2] && (q_t != '0)) ||
               (q_t < eps_ff) || (q_t > tmax_t);
   end

   always_ff @(posedge clock) begin
      if (rdy_t) begin
         for (int i = 0; i < 3; i++) begin
            ot_ff[i]  <= o_t[i];
            dtp_ff[i] <= DTW'(d_t[i]) * $signed({1'b0, q_t});
         end
         tt_ff    <= q_t;
         missT_ff <= miss_t;
         backT_ff <= ctx_t[3];
      end
   end

   // Stage P: hit point.
   logic signed [W-1:0] pp_ff [3];
   logic [QB-1:0]       tp_ff;
   logic                missP_ff, backP_ff;

   always_ff @(posedge clock) begin
      if (rdy_p) begin
         for (int i = 0; i < 3; i++) begin
            pp_ff[i] <= sat_coord(SW'(ot_ff[i]) + SW'(dtp_ff[i] >>> F));
         end
         tp_ff    <= tt_ff;
         missP_ff <= missT_ff;
         backP_ff <= backT_ff;
      end
   end

   // Stage Q: point relative to each edge start.
   logic signed [QW-1:0] qd_ff [3][3];
   logic signed [W-1:0]  pq_ff [3];
   logic [QB-1:0]        tq_ff;
   logic                 missQ_ff, backQ_ff;

   always_ff @(posedge clock) begin
      if (rdy_q) begin
         for (int e = 0; e < 3; e++) begin
            for (int i = 0; i < 3; i++) begin
               qd_ff[e][i] <= QW'(pp_ff[i]) - QW'(vtx[e][i]);
            end
         end
         pq_ff    <= pp_ff;
         tq_ff    <= tp_ff;
         missQ_ff <= missP_ff;
         backQ_ff <= backP_ff;
      end
   end

   // Stage X: cross product terms.
   logic signed [XW-1:0] xp_ff [3][3][2];
   logic signed [W-1:0]  px_ff [3];
   logic [QB-1:0]        tx_ff;
   logic                 missX_ff, backX_ff;

   always_ff @(posedge clock) begin
      if (rdy_x) begin
         for (int e = 0; e < 3; e++) begin
            xp_ff[e][0][0] <= XW'(edge_v[e][1]) * XW'(qd_ff[e][2]);
            xp_ff[e][0][1] <= XW'(edge_v[e][2]) * XW'(qd_ff[e][1]);
            xp_ff[e][1][0] <= XW'(edge_v[e][2]) * XW'(qd_ff[e][0]);
            xp_ff[e][1][1] <= XW'(edge_v[e][0]) * XW'(qd_ff[e][2]);
            xp_ff[e][2][0] <= XW'(edge_v[e][0]) * XW'(qd_ff[e][1]);
            xp_ff[e][2][1] <= XW'(edge_v[e][1]) * XW'(qd_ff[e][0]);
         end
         px_ff    <= pq_ff;
         tx_ff    <= tq_ff;
         missX_ff <= missQ_ff;
         backX_ff <= backQ_ff;
      end
   end

   // Stage C: cross product components, floored to coordinate scale.
   logic signed [CRW-1:0] cr_ff [3][3];
   logic signed [XW:0]    cr_full [3][3];
   logic signed [W-1:0]   pc_ff [3];
   logic [QB-1:0]         tc_ff;
   logic                  missC_ff, backC_ff;

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         for (int k = 0; k < 3; k++) begin
            cr_full[e][k] = ((XW+1)'(xp_ff[e][k][0]) - (XW+1)'(xp_ff[e][k][1])) >>> F;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 3; k++) begin
               cr_ff[e][k] <= cr_full[e][k][CRW-1:0];
            end
         end
         pc_ff    <= px_ff;
         tc_ff    <= tx_ff;
         missC_ff <= missX_ff;
         backC_ff <= backX_ff;
      end
   end

   // Stage M: normal times cross product.
   logic signed [MW-1:0] mp_ff [3][3];
   logic signed [W-1:0]  pm_ff [3];
   logic [QB-1:0]        tm_ff;
   logic                 missM_ff, backM_ff;

   always_ff @(posedge clock) begin
      if (rdy_m) begin
         for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 3; k++) begin
               mp_ff[e][k] <= MW'(cn[k]) * MW'(cr_ff[e][k]);
            end
         end
         pm_ff    <= pc_ff;
         tm_ff    <= tc_ff;
         missM_ff <= missC_ff;
         backM_ff <= backC_ff;
      end
   end

   // Output stage: edge signs and the response word.
   logic signed [SMW-1:0] esum [3];
   logic                  hit_o;

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         esum[e] = SMW'(mp_ff[e][0]) + SMW'(mp_ff[e][1]) + SMW'(mp_ff[e][2]);
      end
      hit_o = !missM_ff && !esum[0][SMW-1] && !esum[1][SMW-1] && !esum[2][SMW-1];
   end

   logic                         hit_ff, back_ff;
   logic [DIST_WIDTH-1:0]        dist_ff;
   logic signed [FIELD_WIDTH-1:0] px_o_ff, py_o_ff, pz_o_ff, nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (rdy_o) begin
         hit_ff <= hit_o;
         if (hit_o) begin
            dist_ff <= tm_ff;
            back_ff <= backM_ff;
            px_o_ff <= FIELD_WIDTH'(pm_ff[0]);
            py_o_ff <= FIELD_WIDTH'(pm_ff[1]);
            pz_o_ff <= FIELD_WIDTH'(pm_ff[2]);
            nx_ff   <= FIELD_WIDTH'(backM_ff ? cn[0] : cn_neg[0]);
            ny_ff   <= FIELD_WIDTH'(backM_ff ? cn[1] : cn_neg[1]);
            nz_ff   <= FIELD_WIDTH'(backM_ff ? cn[2] : cn_neg[2]);
         end else begin
            dist_ff <= '0;
            back_ff <= 1'b0;
            px_o_ff <= '0;
            py_o_ff <= '0;
            pz_o_ff <= '0;
            nx_ff   <= '0;
            ny_ff   <= '0;
            nz_ff   <= '0;
         end
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_distance  = dist_ff;
   assign rsp_back_face = back_ff;
   assign rsp_hit_x     = px_o_ff;
   assign rsp_hit_y     = py_o_ff;
   assign rsp_hit_z     = pz_o_ff;
   assign rsp_shade_nx  = nx_ff;
   assign rsp_shade_ny  = ny_ff;
   assign rsp_shade_nz  = nz_ff;

endmodule

// ===== rtl/rti_checker.sv =====
module rti_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_hit,
   input logic [rti_pkg::DIST_WIDTH-1:0]        rsp_distance,
   input logic                                  rsp_back_face,
   input logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_hit_x,
   input logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_hit_y,
   input logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_hit_z,
   input logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_shade_nx,
   input logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_shade_ny,
   input logic signed [rti_pkg::FIELD_WIDTH-1:0] rsp_shade_nz
);

   // A missed ray reports an all-zero word.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_distance == '0 && !rsp_back_face &&
      rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0 &&
      rsp_shade_nx == '0 && rsp_shade_ny == '0 && rsp_shade_nz == '0)
      else $error("miss word carries nonzero fields");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds; checked on valid, hit, distance and hit_x.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_distance) && $stable(rsp_hit_x))
      else $error("stalled response changed");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

// ===== sim/ray_triangle_intersect_tb.sv =====
module ray_triangle_intersect_tb;
   import rti_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int PIPE_DRAIN = 40;
   localparam longint ONE_NORMAL = 64'sd524288;
   localparam longint COORD_MAX = 64'sd1048575;
   localparam longint COORD_MIN = -64'sd1048576;

   typedef longint vec3_type [3];

   typedef struct {
      logic signed [FIELD_WIDTH-1:0] ox, oy, oz, dx, dy, dz;
      logic [DIST_WIDTH-1:0] tmax;
   } ray_type;

   typedef struct {
      logic hit;
      logic [DIST_WIDTH-1:0] distance;
      logic back_face;
      logic signed [FIELD_WIDTH-1:0] px, py, pz, nx, ny, nz;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   csr_index_type csr_index = REG_VERTEX_A;
   logic [REG_WIDTH-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [FIELD_WIDTH-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [FIELD_WIDTH-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [DIST_WIDTH-1:0] req_max_distance = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit, rsp_back_face;
   logic [DIST_WIDTH-1:0] rsp_distance;
   logic signed [FIELD_WIDTH-1:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic signed [FIELD_WIDTH-1:0] rsp_shade_nx, rsp_shade_ny, rsp_shade_nz;

   ray_triangle_intersect uut (.*);

   logic [REG_WIDTH-1:0] vert_a = '0, vert_b = '0, vert_c = '0, normal_reg = '0;
   logic [FIELD_WIDTH-1:0] offset_reg = '0;
   logic [DIST_WIDTH-1:0] eps_reg = EPSILON_RESET;

   hit_type pending_hits[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int rays_sent = 0;
   int words_checked = 0;
   int hits_seen = 0;
   int back_seen = 0;
   int cycles = 0;
   vec3_type tri_a, tri_b, tri_c;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic longint sx(logic [FIELD_WIDTH-1:0] v);
      return {{(64-FIELD_WIDTH){v[FIELD_WIDTH-1]}}, v};
   endfunction

   function automatic longint clamp(longint v);
      return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
   endfunction

   function automatic vec3_type unpack3(logic [REG_WIDTH-1:0] r);
      vec3_type v;
      for (int i = 0; i < 3; i++) v[i] = sx(r[FIELD_WIDTH*i +: FIELD_WIDTH]);
      return v;
   endfunction

   function automatic logic [REG_WIDTH-1:0] pack3(longint x, longint y, longint z);
      logic [FIELD_WIDTH-1:0] fx, fy, fz;
      fx = x[FIELD_WIDTH-1:0];
      fy = y[FIELD_WIDTH-1:0];
      fz = z[FIELD_WIDTH-1:0];
      return {fz, fy, fx};
   endfunction

   function automatic bit inside_edge(vec3_type n, vec3_type s, vec3_type e_end, vec3_type p);
      longint e[3], q[3], c0, c1, c2;
      for (int i = 0; i < 3; i++) begin
         e[i] = e_end[i] - s[i];
         q[i] = p[i] - s[i];
      end
      c0 = (e[1] * q[2] - e[2] * q[1]) >>> DEF_COORD_FRAC;
      c1 = (e[2] * q[0] - e[0] * q[2]) >>> DEF_COORD_FRAC;
      c2 = (e[0] * q[1] - e[1] * q[0]) >>> DEF_COORD_FRAC;
      return (n[0] * c0 + n[1] * c1 + n[2] * c2) >= 0;
   endfunction

   function automatic hit_type trace_ray(ray_type r);
      vec3_type n, a, b, c, o, d, p;
      longint nd, num, t, eps;
      hit_type res;
      res = '{default: '0};
      n = unpack3(normal_reg);
      a = unpack3(vert_a);
      b = unpack3(vert_b);
      c = unpack3(vert_c);
      o = '{sx(r.ox), sx(r.oy), sx(r.oz)};
      d = '{sx(r.dx), sx(r.dy), sx(r.dz)};
      eps = eps_reg;
      nd = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
      if (nd == 0 || (nd < 0 ? -nd : nd) < (eps <<< (DEF_COORD_WIDTH - 2))) return res;
      num = sx(offset_reg) * ONE_NORMAL - (n[0] * o[0] + n[1] * o[1] + n[2] * o[2]);
      t = (num * 64'sd4096) / nd;
      if (t < eps || t > longint'(r.tmax)) return res;
      for (int i = 0; i < 3; i++) p[i] = clamp(o[i] + ((d[i] * t) >>> DEF_COORD_FRAC));
      if (!inside_edge(n, a, b, p) || !inside_edge(n, b, c, p) || !inside_edge(n, c, a, p))
         return res;
      res.hit = 1'b1;
      res.distance = t[DIST_WIDTH-1:0];
      res.back_face = nd < 0;
      res.px = p[0][FIELD_WIDTH-1:0];
      res.py = p[1][FIELD_WIDTH-1:0];
      res.pz = p[2][FIELD_WIDTH-1:0];
      for (int i = 0; i < 3; i++) if (!res.back_face) n[i] = clamp(-n[i]);
      res.nx = n[0][FIELD_WIDTH-1:0];
      res.ny = n[1][FIELD_WIDTH-1:0];
      res.nz = n[2][FIELD_WIDTH-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("mismatch on word %0d: %s is %0h, expected %0h", words_checked, field, got, want);
   endtask

   always @(posedge clock) begin
      hit_type want;
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_distance !== want.distance)
               report_mismatch("distance", rsp_distance, want.distance);
            if (rsp_back_face !== want.back_face)
               report_mismatch("back_face", rsp_back_face, want.back_face);
            if (rsp_hit_x !== want.px) report_mismatch("hit_x", rsp_hit_x, want.px);
            if (rsp_hit_y !== want.py) report_mismatch("hit_y", rsp_hit_y, want.py);
            if (rsp_hit_z !== want.pz) report_mismatch("hit_z", rsp_hit_z, want.pz);
            if (rsp_shade_nx !== want.nx) report_mismatch("shade_nx", rsp_shade_nx, want.nx);
            if (rsp_shade_ny !== want.ny) report_mismatch("shade_ny", rsp_shade_ny, want.ny);
            if (rsp_shade_nz !== want.nz) report_mismatch("shade_nz", rsp_shade_nz, want.nz);
         end
         words_checked++;
         if (rsp_hit === 1'b1) hits_seen++;
         if (rsp_hit === 1'b1 && rsp_back_face === 1'b1) back_seen++;
      end
   end

   task automatic send_ray(ray_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= r.ox;
      req_origin_y <= r.oy;
      req_origin_z <= r.oz;
      req_dir_x <= r.dx;
      req_dir_y <= r.dy;
      req_dir_z <= r.dz;
      req_max_distance <= r.tmax;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_hits.push_back(trace_ray(r));
      rays_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [REG_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_VERTEX_A: vert_a = value;
         REG_VERTEX_B: vert_b = value;
         REG_VERTEX_C: vert_c = value;
         REG_PLANE_NORMAL: normal_reg = value;
         REG_PLANE_OFFSET: offset_reg = value[FIELD_WIDTH-1:0];
         REG_EPSILON: eps_reg = value[DIST_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic ray_type make_ray(longint ox, longint oy, longint oz,
                                        longint dx, longint dy, longint dz, longint tmax);
      ray_type r;
      r.ox = ox[FIELD_WIDTH-1:0];
      r.oy = oy[FIELD_WIDTH-1:0];
      r.oz = oz[FIELD_WIDTH-1:0];
      r.dx = dx[FIELD_WIDTH-1:0];
      r.dy = dy[FIELD_WIDTH-1:0];
      r.dz = dz[FIELD_WIDTH-1:0];
      r.tmax = tmax[DIST_WIDTH-1:0];
      return r;
   endfunction

   function automatic ray_type noise_ray();
      return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic longint srand(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   // Builds a triangle in a plane normal to one axis, with the normal sign (or, for the most
   // negative normal, the winding) chosen so that interior points pass the edge tests.
   task automatic load_triangle(int ax, int span, bit most_negative, int eps);
      int u, v;
      longint k, cr, sgn, nv;
      vec3_type n;
      u = (ax + 1) % 3;
      v = (ax + 2) % 3;
      k = most_negative ? srand(65536) : srand(131072);
      do begin
         for (int i = 0; i < 3; i++) begin
            tri_a[i] = srand(span);
            tri_b[i] = srand(span);
            tri_c[i] = srand(span);
         end
         tri_a[ax] = k;
         tri_b[ax] = k;
         tri_c[ax] = k;
         cr = (tri_b[u] - tri_a[u]) * (tri_c[v] - tri_a[v])
            - (tri_b[v] - tri_a[v]) * (tri_c[u] - tri_a[u]);
         if (most_negative && cr > 0) begin
            n = tri_b;
            tri_b = tri_c;
            tri_c = n;
            cr = -cr;
         end
      end while (cr == 0);
      sgn = (cr > 0) ? 1 : -1;
      nv = most_negative ? COORD_MIN : sgn * ONE_NORMAL;
      n = '{0, 0, 0};
      n[ax] = nv;
      write_reg(REG_VERTEX_A, pack3(tri_a[0], tri_a[1], tri_a[2]));
      write_reg(REG_VERTEX_B, pack3(tri_b[0], tri_b[1], tri_b[2]));
      write_reg(REG_VERTEX_C, pack3(tri_c[0], tri_c[1], tri_c[2]));
      write_reg(REG_PLANE_NORMAL, pack3(n[0], n[1], n[2]));
      write_reg(REG_PLANE_OFFSET, REG_WIDTH'((nv * k) >>> (DEF_COORD_WIDTH - 2)));
      write_reg(REG_EPSILON, REG_WIDTH'(eps));
   endtask

   function automatic ray_type aimed_ray();
      longint w1, w2, s, tgt[3], d[3];
      w1 = $urandom_range(1023);
      w2 = $urandom_range(1023);
      if (w1 + w2 > 1023) begin
         w1 = 1023 - w1;
         w2 = 1023 - w2;
      end
      s = $urandom_range(32768, 256);
      for (int i = 0; i < 3; i++) begin
         tgt[i] = tri_a[i] + ((tri_b[i] - tri_a[i]) * w1 + (tri_c[i] - tri_a[i]) * w2) / 1024;
         d[i] = srand(16384);
      end
      return make_ray(tgt[0] - d[0] * s / 4096, tgt[1] - d[1] * s / 4096,
                      tgt[2] - d[2] * s / 4096, d[0], d[1], d[2],
                      ($urandom_range(3) == 0) ? $urandom_range(40000) : 20'hFFFFF);
   endfunction

   task automatic test_reset_defaults();
      send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        20'hFFFFF));
      send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_special_cases();
      load_triangle(2, 65536, 1'b0, 4);
      write_reg(REG_VERTEX_A, pack3(-65536, -65536, 0));
      write_reg(REG_VERTEX_B, pack3(65536, -65536, 0));
      write_reg(REG_VERTEX_C, pack3(0, 65536, 0));
      tri_a = '{-65536, -65536, 0};
      tri_b = '{65536, -65536, 0};
      tri_c = '{0, 65536, 0};
      write_reg(REG_PLANE_NORMAL, pack3(0, 0, ONE_NORMAL));
      write_reg(REG_PLANE_OFFSET, '0);
      send_ray(make_ray(0, 0, 8192, 0, 0, -4096, 20'hFFFFF));
      send_ray(make_ray(0, 0, -8192, 0, 0, 4096, 20'hFFFFF));
      send_ray(make_ray(0, 0, 8192, 4096, 0, 0, 20'hFFFFF));
      send_ray(make_ray(0, 0, 0, 0, 0, -4096, 20'hFFFFF));
      send_ray(make_ray(0, 0, 8192, 0, 0, -4096, 0));
      send_ray(make_ray(0, 0, 8192, 0, 0, -4096, 8191));
      send_ray(make_ray(900000, 0, 4096, COORD_MAX, 0, -4096, 20'hFFFFF));
      send_ray(make_ray(0, 0, 4096, 0, 0, COORD_MIN, 20'hFFFFF));
      send_ray(make_ray(200000, 0, 8192, 0, 0, -4096, 20'hFFFFF));
      send_ray(make_ray(-65536, -65536, 4096, 0, 0, -4096, 20'hFFFFF));
      send_ray(make_ray(COORD_MAX, COORD_MIN, COORD_MAX, 1, -1, COORD_MIN, 20'hFFFFF));
      wait_idle();
      write_reg(REG_EPSILON, '0);
      send_ray(make_ray(0, 0, 8192, 4096, 4096, 0, 20'hFFFFF));
      send_ray(make_ray(0, 0, 8192, 0, 0, -1, 20'hFFFFF));
      wait_idle();
      write_reg(REG_EPSILON, REG_WIDTH'(20'hFFFFF));
      send_ray(make_ray(0, 0, 8192, 0, 0, COORD_MIN, 20'hFFFFF));
      wait_idle();
      load_triangle(0, 65536, 1'b1, 0);
      for (int i = 0; i < 6; i++) send_ray(aimed_ray());
      wait_idle();
   endtask

   task automatic test_aimed_rays(int idle, int stall, int count);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            wait_idle();
            load_triangle($urandom_range(2), $urandom_range(262143, 4096),
                          $urandom_range(7) == 0,
                          ($urandom_range(3) == 0) ? 0 : $urandom_range(64));
         end
         send_ray(($urandom_range(9) == 0) ? noise_ray() : aimed_ray());
      end
      wait_idle();
   endtask

   task automatic test_noise(int count);
      idle_pct = 20;
      stall_pct = 20;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            wait_idle();
            for (int r = 0; r <= REG_EPSILON; r++)
               write_reg(csr_index_type'(r), REG_WIDTH'({$urandom, $urandom}));
         end
         send_ray(noise_ray());
      end
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_special_cases();
      test_aimed_rays(0, 0, 360);
      test_aimed_rays(78, 0, 330);
      test_aimed_rays(0, 78, 330);
      test_aimed_rays(37, 37, 330);
      test_noise(200);
      $display("Sent %0d rays over axis-aligned and random triangles; %0d words checked.",
               rays_sent, words_checked);
      $display("Saw %0d hits, %0d of them on the back face.", hits_seen, back_seen);
      if (errors == 0 && pending_hits.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d words missing", errors, pending_hits.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rti_pkg.sv
rtl/rti_div_stage.sv
rtl/ray_triangle_intersect.sv
rtl/rti_checker.sv
sim/ray_triangle_intersect_tb.sv
